// File: hw/rtl/abhe_pkg.sv
package abhe_pkg;

   // Coefficient and datapath widths
   localparam int COEF_W     = 16;
   localparam int MUL_A_W    = COEF_W + 1;          // holds 65536 - c
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;   // 49
   localparam int ENV_W      = 32;
   localparam int LVL_W      = 16;
   localparam int AMP_W      = 7;
   localparam int SMOOTH_W   = 23;
   localparam int DEC_W      = 4;
   localparam int GATE_W     = 7;
   localparam int QUO_W      = 8;                   // 7 quotient bits plus overflow bit
   localparam int DIV_CNT_W  = 3;

   localparam logic [MUL_A_W-1:0] Q16_ONE   = 17'h10000;
   localparam logic [MUL_A_W-1:0] MAP_GAIN  = 17'd127;
   localparam logic [AMP_W-1:0]   AMP_MAX   = 7'd127;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MUSIC_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_ALPHA     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DECIMATION    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SMOOTH_FACTOR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GATE_LEVEL    = 3'd5;

   localparam logic [COEF_W-1:0] RST_ENV_ALPHA     = 16'd3277;
   localparam logic [DEC_W-1:0]  RST_DECIMATION    = 4'd10;
   localparam logic [LVL_W-1:0]  RST_FULL_SCALE    = 16'd12000;
   localparam logic [COEF_W-1:0] RST_SMOOTH_FACTOR = 16'd19661;
   localparam logic [GATE_W-1:0] RST_GATE_LEVEL    = 7'd25;

   // Operand pair for the shared multiplier
   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

endpackage

// File: hw/rtl/abhe_mul.sv
module abhe_mul (
   input  logic                          clock,
   input  abhe_pkg::mul_op_type          op,
   output logic [abhe_pkg::PROD_W-1:0]   prod
);
   import abhe_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // unsigned 17 x 32, registered
   assign prod_in = PROD_W'(op.a) * PROD_W'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: hw/rtl/audio_bass_haptic_envelope.sv
// Bass envelope to haptic amplitude. Sample transactions (cmd 0) feed the
// magnitude of every Nth sample of a buffer into a Q16 exponential envelope
// and track the running maximum of its integer part; the last sample of a
// buffer latches that maximum as the bass level. Tick transactions (cmd 1)
// map the bass level to 0..127 (level * 127 / full_scale, clamped), pass it
// through a second Q16 moving average, gate values below gate_level to zero
// and return one result: amplitude and drive_on. Sample transactions return
// nothing; with music_enable low every transaction is taken and dropped.
// Any write to music_enable clears the smoother. Configuration must be
// written only while the block is idle; the block does not enforce it.
// req_stall is high while a transaction is in work: a used sample runs E1
// to E3 and SFIN, a skipped (decimated) sample SFIN, a tick T1 to T5 with
// DIV and waits in T5 for the output register to drain; a disabled one
// starts no work. All filter arithmetic goes through one registered 17 x 32
// multiplier, two passes per filter update; the division by full_scale is
// a restoring divider retiring one quotient bit a cycle. An output register
// holds the result, so samples flow on while a result waits on rsp_stall.
module audio_bass_haptic_envelope #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_last_in_buffer,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [abhe_pkg::AMP_W-1:0]            rsp_amplitude,
   output logic                                  rsp_drive_on,

   input  logic                                  csr_write_en,
   input  logic [abhe_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [abhe_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import abhe_pkg::*;

   // Sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_E1   = 4'd1;   // alpha * |x|
   localparam logic [3:0] ST_E2   = 4'd2;   // (1 - alpha) * envelope
   localparam logic [3:0] ST_E3   = 4'd3;   // sum, saturate
   localparam logic [3:0] ST_SFIN = 4'd4;   // running max, phase, buffer end
   localparam logic [3:0] ST_T1   = 4'd5;   // bass * 127
   localparam logic [3:0] ST_T2   = 4'd6;   // load divider
   localparam logic [3:0] ST_DIV  = 4'd7;   // one quotient bit per cycle
   localparam logic [3:0] ST_T3   = 4'd8;   // smooth * mapped
   localparam logic [3:0] ST_T4   = 4'd9;   // (1 - smooth) * smoothed
   localparam logic [3:0] ST_T5   = 4'd10;  // sum, gate, load output

   localparam int DIVR_W = SMOOTH_W;  // dividend bass * 127 fits 23 bits

   // Configuration registers
   logic                 enable_ff;
   logic [COEF_W-1:0]    alpha_ff;
   logic [DEC_W-1:0]     dec_ff;
   logic [LVL_W-1:0]     fs_ff;
   logic [COEF_W-1:0]    smooth_ff;
   logic [GATE_W-1:0]    gate_ff;

   // Filter state
   logic [ENV_W-1:0]     envelope_ff;
   logic [DEC_W-1:0]     phase_ff;
   logic [LVL_W-1:0]     block_max_ff;
   logic [LVL_W-1:0]     bass_ff;
   logic [SMOOTH_W-1:0]  smoothed_ff;

   // Sequencer and working registers
   logic [3:0]           state_ff, state_in;
   logic [MUL_B_W-1:0]   mag_ff;
   logic                 last_ff;
   logic                 used_ff;
   logic [PROD_W-1:0]    acc_ff;
   logic [DIVR_W-1:0]    rem_ff;
   logic [DIVR_W-1:0]    divisor_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   // Output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [AMP_W-1:0]     amp_ff;
   logic                 drive_ff;

   // Shared multiplier
   mul_op_type           mul_op;
   logic [PROD_W-1:0]    prod;

   abhe_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   logic                 req_take;
   logic                 slot_free;
   logic [SAMPLE_BITS-1:0] mag;
   logic [PROD_W-1:0]    filt_sum;
   logic [DIVR_W:0]      trial;
   logic [AMP_W-1:0]     mapped;
   logic [LVL_W-1:0]     lvl;
   logic [LVL_W-1:0]     max_new;
   logic [DEC_W-1:0]     dec_eff;
   logic [DEC_W-1:0]     phase_nxt;
   logic [DEC_W-1:0]     phase_wrap;
   logic [LVL_W-1:0]     fs_eff;
   logic [AMP_W-1:0]     amp_raw;
   logic [AMP_W-1:0]     amp_gated;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // |sample|; the most negative code maps to 2^(SAMPLE_BITS-1)
   assign mag = req_sample[SAMPLE_BITS-1] ? (~req_sample + 1'b1) : req_sample;

   // Q16 update: c*x + ((1-c)*old >> 16); acc holds c*x
   assign filt_sum = acc_ff + {16'd0, prod[PROD_W-1:16]};

   // restoring division step
   assign trial = {1'b0, rem_ff} - {1'b0, divisor_ff};

   // quotient of 128 or more clamps
   assign mapped = quo_ff[QUO_W-1] ? AMP_MAX : quo_ff[AMP_W-1:0];

   assign lvl     = envelope_ff[ENV_W-1:ENV_W-LVL_W];
   assign max_new = (used_ff && (lvl > block_max_ff)) ? lvl : block_max_ff;

   assign dec_eff    = (dec_ff == '0) ? DEC_W'(1) : dec_ff;
   assign phase_nxt  = phase_ff + 1'b1;
   assign phase_wrap = (phase_nxt >= dec_eff) ? '0 : phase_nxt;

   assign fs_eff = (fs_ff == '0) ? LVL_W'(1) : fs_ff;

   // smoothed value is below 2^23, so its integer part is at most 127
   assign amp_raw   = filt_sum[SMOOTH_W-1:16];
   assign amp_gated = (amp_raw < gate_ff) ? '0 : amp_raw;

   // Multiplier operand select
   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         ST_E1: begin
            mul_op.a = MUL_A_W'(alpha_ff);
            mul_op.b = mag_ff;
         end
         ST_E2: begin
            mul_op.a = Q16_ONE - MUL_A_W'(alpha_ff);
            mul_op.b = envelope_ff;
         end
         ST_T1: begin
            mul_op.a = MAP_GAIN;
            mul_op.b = MUL_B_W'(bass_ff);
         end
         ST_T3: begin
            mul_op.a = MUL_A_W'(smooth_ff);
            mul_op.b = MUL_B_W'(mapped);
         end
         // operands held through T5 so the product stays put while the
         // output register is still busy
         ST_T4, ST_T5: begin
            mul_op.a = Q16_ONE - MUL_A_W'(smooth_ff);
            mul_op.b = MUL_B_W'(smoothed_ff);
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && enable_ff) begin
               if (req_cmd) begin
                  state_in = ST_T1;
               end else if (phase_ff == '0) begin
                  state_in = ST_E1;
               end else begin
                  state_in = ST_SFIN;
               end
            end
         end
         ST_E1:   state_in = ST_E2;
         ST_E2:   state_in = ST_E3;
         ST_E3:   state_in = ST_SFIN;
         ST_SFIN: state_in = ST_IDLE;
         ST_T1:   state_in = ST_T2;
         ST_T2:   state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = ST_T3;
            end
         end
         ST_T3:   state_in = ST_T4;
         ST_T4:   state_in = ST_T5;
         ST_T5: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_T5 && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         alpha_ff     <= RST_ENV_ALPHA;
         dec_ff       <= RST_DECIMATION;
         fs_ff        <= RST_FULL_SCALE;
         smooth_ff    <= RST_SMOOTH_FACTOR;
         gate_ff      <= RST_GATE_LEVEL;
         envelope_ff  <= '0;
         phase_ff     <= '0;
         block_max_ff <= '0;
         bass_ff      <= '0;
         smoothed_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;

         if (csr_write_en) begin
            unique case (csr_index)
               REG_MUSIC_ENABLE: begin
                  enable_ff   <= csr_wdata[0];
                  smoothed_ff <= '0;
               end
               REG_ENV_ALPHA:     alpha_ff  <= csr_wdata;
               REG_DECIMATION:    dec_ff    <= csr_wdata[DEC_W-1:0];
               REG_FULL_SCALE:    fs_ff     <= csr_wdata;
               REG_SMOOTH_FACTOR: smooth_ff <= csr_wdata;
               REG_GATE_LEVEL:    gate_ff   <= csr_wdata[GATE_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == ST_E3) begin
            // saturate at 2^32-1
            envelope_ff <= (|filt_sum[PROD_W-1:ENV_W]) ? '1 : filt_sum[ENV_W-1:0];
         end

         if (state_ff == ST_SFIN) begin
            if (last_ff) begin
               bass_ff      <= max_new;
               block_max_ff <= '0;
               phase_ff     <= '0;
            end else begin
               block_max_ff <= max_new;
               phase_ff     <= phase_wrap;
            end
         end

         if (state_ff == ST_T5 && slot_free) begin
            smoothed_ff <= filt_sum[SMOOTH_W-1:0];
         end
      end
   end

   // Working registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         mag_ff  <= {{(MUL_B_W-SAMPLE_BITS){1'b0}}, mag};
         last_ff <= req_last_in_buffer;
         used_ff <= (phase_ff == '0);
      end

      if (state_ff == ST_E2 || state_ff == ST_T4) begin
         acc_ff <= prod;
      end

      if (state_ff == ST_T2) begin
         rem_ff     <= prod[DIVR_W-1:0];
         divisor_ff <= {fs_eff, 7'd0};
         quo_ff     <= '0;
         cnt_ff     <= DIV_CNT_W'(QUO_W - 1);
      end else if (state_ff == ST_DIV) begin
         if (!trial[DIVR_W]) begin
            rem_ff <= trial[DIVR_W-1:0];
         end
         quo_ff     <= {quo_ff[QUO_W-2:0], ~trial[DIVR_W]};
         divisor_ff <= divisor_ff >> 1;
         cnt_ff     <= cnt_ff - 1'b1;
      end

      if (state_ff == ST_T5 && slot_free) begin
         amp_ff   <= amp_gated;
         drive_ff <= (amp_gated != '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_amplitude = amp_ff;
   assign rsp_drive_on  = drive_ff;

   // drive_on follows a nonzero amplitude
   a_drive_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_on == (rsp_amplitude != '0)))
      else $error("drive_on disagrees with amplitude");

   // a nonzero amplitude has passed the gate
   a_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_amplitude != '0)) |-> (rsp_amplitude >= gate_ff))
      else $error("amplitude below gate level");

   // disabled transactions are dropped
   a_disabled: assert property (@(posedge clock) disable iff (reset)
      (req_take && !enable_ff) |=> (state_ff == ST_IDLE))
      else $error("disabled transaction started work");

   // finishing a tick always presents a result
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T5 && slot_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("tick result not loaded");

endmodule
